// ----- design/swr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

    // Field widths of the channels
    localparam int unsigned SAMPLE_W      = 12;
    localparam int unsigned SAMPLE_BITS_DEF = 12;
    localparam int unsigned SCALED_W      = 16;
    localparam int unsigned SWR_W         = 24;
    localparam int unsigned PWR_W         = 32;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned MUL_W         = 16;
    localparam int unsigned DIVS_W        = 24;

    // Shared divider: 32-bit dividend, quotient bits per cycle
    localparam int unsigned DIV_W         = 32;
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_CYCLES    = DIV_W / DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic [SCALED_W-1:0] SCALED_MAX = 16'hFFFF;
    localparam logic [MUL_W-1:0]    SWR_SCALE  = 16'd100;

    // Reset values of the configuration registers
    localparam logic [MUL_W-1:0]  RST_SUPPLY_MUL = 16'd3300;
    localparam logic [DIVS_W-1:0] RST_SUPPLY_DIV = 24'd4095;
    localparam logic [MUL_W-1:0]  RST_BRIDGE_MUL = 16'd3300;
    localparam logic [DIVS_W-1:0] RST_BRIDGE_DIV = 24'd4095;
    localparam logic [PWR_W-1:0]  RST_POWER_DIV  = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUPPLY_MUL = 3'd0,
        CFG_SUPPLY_DIV = 3'd1,
        CFG_BRIDGE_MUL = 3'd2,
        CFG_BRIDGE_DIV = 3'd3,
        CFG_POWER_DIV  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_STORE  = 3'd4,
        OP_FINISH = 3'd5
    } t_dp_op;

    typedef enum logic [2:0] {
        PH_VCC = 3'd0,
        PH_REV = 3'd1,
        PH_FWD = 3'd2,
        PH_SWR = 3'd3,
        PH_PWR = 3'd4
    } t_phase;

    typedef struct packed {
        t_dp_op op;
        t_phase phase;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic swr_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- design/swr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface swr_in_if;
    logic                          valid;
    logic                          ready;
    logic [swr_pkg::SAMPLE_W-1:0]  supply_sample;
    logic [swr_pkg::SAMPLE_W-1:0]  reflected_sample;
    logic [swr_pkg::SAMPLE_W-1:0]  forward_sample;

    modport source (output valid, output supply_sample, output reflected_sample,
                    output forward_sample, input ready);
    modport sink   (input valid, input supply_sample, input reflected_sample,
                    input forward_sample, output ready);
endinterface

interface swr_out_if;
    logic                          valid;
    logic                          ready;
    logic [swr_pkg::SCALED_W-1:0]  supply_voltage;
    logic [swr_pkg::SWR_W-1:0]     swr_times_hundred;
    logic [swr_pkg::PWR_W-1:0]     forward_power;
    logic                          changed;

    modport source (output valid, output supply_voltage, output swr_times_hundred,
                    output forward_power, output changed, input ready);
    modport sink   (input valid, input supply_voltage, input swr_times_hundred,
                    input forward_power, input changed, output ready);
endinterface

interface swr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swr_pkg::CFG_IDX_W-1:0]   index;
    logic [swr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/swr_power_meter_calc_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SWR and forward power calculator for a directional bridge meter.
// i_in carries one measurement tick (supply, reflected, forward ADC counts);
// o_out returns one result item per tick: scaled supply voltage, SWR x 100,
// forward power and a flag set when any result differs from the last tick.
// i_cfg writes the five scale registers by index; it is always ready and
// should only be used while no tick is in flight.
// Each tick runs five multiply/divide passes on one shared 17x16 multiplier
// and one restoring divider that retires 2 quotient bits a cycle: each pass
// is a multiply step, a divide phase and a store step, and a finish step
// loads the output register last. When reflected is at or above forward,
// the ratio pass skips its multiply and divide and stores zero.
// The calculator takes one tick at a time; i_in.ready is high only while
// the calculator is idle.
// The result sits in an output register, so a new tick is taken while the
// previous result still waits; if the receiver stalls, the next result holds
// in the datapath until the output register empties.
// Reset (i_rst_n low, synchronous) restores the register defaults, clears
// the stored last results to zero and drops o_out.valid.
module swr_power_meter_calc_unit #(
    parameter int unsigned SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swr_cfg_if.sink     i_cfg,
    swr_in_if.sink      i_in,
    swr_out_if.source   o_out
);

    swr_pkg::t_dp_cmd cmd;
    swr_pkg::t_dp_sts sts;

    // configuration never stalls
    assign i_cfg.ready = 1'b1;

    swr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    swr_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_idx           (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_supply_sample     (i_in.supply_sample),
        .i_reflected_sample  (i_in.reflected_sample),
        .i_forward_sample    (i_in.forward_sample),
        .o_supply_voltage    (o_out.supply_voltage),
        .o_swr_times_hundred (o_out.swr_times_hundred),
        .o_forward_power     (o_out.forward_power),
        .o_changed           (o_out.changed)
    );

    // leave reset idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in.ready && !o_out.valid))
        else $error("block not idle after reset");

    // one tick at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a tick is in flight");

    // a nonzero ratio is never below 1.00
    a_swr_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.swr_times_hundred != '0) |->
            (o_out.swr_times_hundred >= 24'd100))
        else $error("swr result below unity");

endmodule

`default_nettype wire

// ----- design/swr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output swr_pkg::t_dp_cmd o_cmd,
    input  swr_pkg::t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_DIV    = 5'b00100,
        S_STORE  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    swr_pkg::t_phase  r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    function automatic swr_pkg::t_phase next_phase(input swr_pkg::t_phase ph);
        swr_pkg::t_phase nx;
        case (ph)
            swr_pkg::PH_VCC: nx = swr_pkg::PH_REV;
            swr_pkg::PH_REV: nx = swr_pkg::PH_FWD;
            swr_pkg::PH_FWD: nx = swr_pkg::PH_SWR;
            swr_pkg::PH_SWR: nx = swr_pkg::PH_PWR;
            default:         nx = swr_pkg::PH_PWR;
        endcase
        return nx;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        o_cmd.op    = swr_pkg::OP_NONE;
        o_cmd.phase = r_phase;
        out_free    = !r_out_valid || i_out_ready;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = swr_pkg::OP_LOAD;
                    n_phase  = swr_pkg::PH_VCC;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                // reflected at or above forward: skip the ratio division
                if (r_phase == swr_pkg::PH_SWR && i_sts.swr_zero) begin
                    o_cmd.op = swr_pkg::OP_STORE;
                    n_phase  = swr_pkg::PH_PWR;
                end else begin
                    o_cmd.op = swr_pkg::OP_MUL;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = swr_pkg::OP_DIV;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.op = swr_pkg::OP_STORE;
                if (r_phase == swr_pkg::PH_PWR) begin
                    n_state = S_FINISH;
                end else begin
                    n_phase = next_phase(r_phase);
                    n_state = S_MUL;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.op    = swr_pkg::OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= swr_pkg::PH_VCC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/swr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swr_dp #(
    parameter int unsigned SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swr_pkg::t_dp_cmd                  i_cmd,
    output swr_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [swr_pkg::SAMPLE_W-1:0]      i_supply_sample,
    input  logic [swr_pkg::SAMPLE_W-1:0]      i_reflected_sample,
    input  logic [swr_pkg::SAMPLE_W-1:0]      i_forward_sample,
    output logic [swr_pkg::SCALED_W-1:0]      o_supply_voltage,
    output logic [swr_pkg::SWR_W-1:0]         o_swr_times_hundred,
    output logic [swr_pkg::PWR_W-1:0]         o_forward_power,
    output logic                              o_changed
);

    localparam int unsigned SW = swr_pkg::SCALED_W;
    localparam int unsigned DW = swr_pkg::DIV_W;
    localparam logic [SW-1:0] SampleMask = SW'((17'd1 << SAMPLE_BITS) - 17'd1);
    localparam logic [swr_pkg::DIV_CNT_W-1:0] DivLast =
        swr_pkg::DIV_CNT_W'(swr_pkg::DIV_CYCLES - 1);

    // configuration
    logic [swr_pkg::MUL_W-1:0]  r_supply_mul;
    logic [swr_pkg::DIVS_W-1:0] r_supply_div;
    logic [swr_pkg::MUL_W-1:0]  r_bridge_mul;
    logic [swr_pkg::DIVS_W-1:0] r_bridge_div;
    logic [swr_pkg::PWR_W-1:0]  r_power_div;

    // working registers
    logic [SW-1:0]              r_smp_vcc, r_smp_rev, r_smp_fwd;
    logic [SW-1:0]              r_vcc, r_rev, r_fwd;
    logic [swr_pkg::SWR_W-1:0]  r_swr;
    logic [swr_pkg::PWR_W-1:0]  r_pwr;
    logic [DW-1:0]              r_rem, r_quo, r_dvs;
    logic [swr_pkg::DIV_CNT_W-1:0] r_cnt;

    // results, also the last-result state
    logic [SW-1:0]              r_out_vcc;
    logic [swr_pkg::SWR_W-1:0]  r_out_swr;
    logic [swr_pkg::PWR_W-1:0]  r_out_pwr;
    logic                       r_out_chg;

    logic [SW-1:0]              rev_clamp;
    logic [SW-1:0]              diff;
    logic [SW:0]                sum;
    logic [SW:0]                mul_a;
    logic [swr_pkg::MUL_W-1:0]  mul_b;
    logic [DW-1:0]              mul_p;
    logic [DW-1:0]              dvs_sel;
    logic [DW-1:0]              n_rem, n_quo;
    logic [SW-1:0]              quo_sat;

    // reflected clamped to forward
    assign rev_clamp = (r_rev > r_fwd) ? r_fwd : r_rev;
    assign sum       = {1'b0, r_fwd} + {1'b0, rev_clamp};
    assign diff      = r_fwd - rev_clamp;
    assign o_sts.swr_zero = (r_rev >= r_fwd);
    assign o_sts.div_last = (r_cnt == DivLast);

    // operand and divisor select for the shared multiplier and divider
    always_comb begin
        case (i_cmd.phase)
            swr_pkg::PH_VCC: begin
                mul_a   = {1'b0, r_smp_vcc};
                mul_b   = r_supply_mul;
                dvs_sel = DW'(r_supply_div);
            end
            swr_pkg::PH_REV: begin
                mul_a   = {1'b0, r_smp_rev};
                mul_b   = r_bridge_mul;
                dvs_sel = DW'(r_bridge_div);
            end
            swr_pkg::PH_FWD: begin
                mul_a   = {1'b0, r_smp_fwd};
                mul_b   = r_bridge_mul;
                dvs_sel = DW'(r_bridge_div);
            end
            swr_pkg::PH_SWR: begin
                mul_a   = sum;
                mul_b   = swr_pkg::SWR_SCALE;
                dvs_sel = DW'(diff);
            end
            default: begin
                mul_a   = {1'b0, r_fwd};
                mul_b   = r_fwd;
                dvs_sel = r_power_div;
            end
        endcase
    end

    // products stay below 2^32 for every phase
    assign mul_p = DW'(mul_a * mul_b);

    // restoring division, DIV_BITS_PER_CYCLE quotient bits per cycle; divisor zero gives all ones
    always_comb begin
        logic [DW:0] sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < swr_pkg::DIV_BITS_PER_CYCLE; i++) begin
            sh    = {n_rem, n_quo[DW-1]};
            n_quo = {n_quo[DW-2:0], 1'b0};
            if (sh >= {1'b0, r_dvs}) begin
                n_rem    = DW'(sh - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem    = sh[DW-1:0];
            end
        end
    end

    assign quo_sat = (r_quo > DW'(swr_pkg::SCALED_MAX)) ? swr_pkg::SCALED_MAX : r_quo[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply_mul <= swr_pkg::RST_SUPPLY_MUL;
            r_supply_div <= swr_pkg::RST_SUPPLY_DIV;
            r_bridge_mul <= swr_pkg::RST_BRIDGE_MUL;
            r_bridge_div <= swr_pkg::RST_BRIDGE_DIV;
            r_power_div  <= swr_pkg::RST_POWER_DIV;
            r_out_vcc    <= '0;
            r_out_swr    <= '0;
            r_out_pwr    <= '0;
            r_out_chg    <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swr_pkg::CFG_SUPPLY_MUL: r_supply_mul <= i_cfg_data[swr_pkg::MUL_W-1:0];
                    swr_pkg::CFG_SUPPLY_DIV: r_supply_div <= i_cfg_data[swr_pkg::DIVS_W-1:0];
                    swr_pkg::CFG_BRIDGE_MUL: r_bridge_mul <= i_cfg_data[swr_pkg::MUL_W-1:0];
                    swr_pkg::CFG_BRIDGE_DIV: r_bridge_div <= i_cfg_data[swr_pkg::DIVS_W-1:0];
                    swr_pkg::CFG_POWER_DIV:  r_power_div  <= i_cfg_data[swr_pkg::PWR_W-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                swr_pkg::OP_MUL: r_cnt <= '0;
                swr_pkg::OP_DIV: r_cnt <= r_cnt + 1'b1;
                swr_pkg::OP_FINISH: begin
                    r_out_chg <= (r_vcc != r_out_vcc) || (r_swr != r_out_swr) ||
                                 (r_pwr != r_out_pwr);
                    r_out_vcc <= r_vcc;
                    r_out_swr <= r_swr;
                    r_out_pwr <= r_pwr;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            swr_pkg::OP_LOAD: begin
                r_smp_vcc <= SW'(i_supply_sample) & SampleMask;
                r_smp_rev <= SW'(i_reflected_sample) & SampleMask;
                r_smp_fwd <= SW'(i_forward_sample) & SampleMask;
            end
            swr_pkg::OP_MUL: begin
                r_quo <= mul_p;
                r_rem <= '0;
                r_dvs <= dvs_sel;
            end
            swr_pkg::OP_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
            end
            swr_pkg::OP_STORE: begin
                case (i_cmd.phase)
                    swr_pkg::PH_VCC: r_vcc <= quo_sat;
                    swr_pkg::PH_REV: r_rev <= quo_sat;
                    swr_pkg::PH_FWD: r_fwd <= quo_sat;
                    swr_pkg::PH_SWR: r_swr <= o_sts.swr_zero ? '0 : r_quo[swr_pkg::SWR_W-1:0];
                    default:         r_pwr <= r_quo;
                endcase
            end
            default: ;
        endcase
    end

    assign o_supply_voltage    = r_out_vcc;
    assign o_swr_times_hundred = r_out_swr;
    assign o_forward_power     = r_out_pwr;
    assign o_changed           = r_out_chg;

endmodule

`default_nettype wire
